[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the lcg random generator blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and reset.
`define LRDG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Short form for modules with the standard clock and reset port names.
`define LRDG_ASSERT_STD(label, prop, msg) \
   `LRDG_ASSERT(label, clock, reset, prop, msg)

`endif

[sv/lrdg_pkg.sv]
// ---------------------------------------------------------------------------
// lrdg_pkg
// Widths, codes and microcode program of the lcg random generator.
// ---------------------------------------------------------------------------
package lrdg_pkg;

   localparam int GaussDraws = 12;

   localparam int LcgW   = 31;
   localparam int UW     = 15;
   localparam int OpW    = 3;
   localparam int SigW   = 24;
   localparam int SeedW  = 32;
   localparam int ValW   = 32;
   localparam int FracW  = 16;
   localparam int SumW   = $clog2(GaussDraws * 32767 + 1);
   localparam int DW     = SumW + 2;
   localparam int ProdW  = SigW + DW;
   localparam int RndW   = ProdW + 1;
   localparam int SatW   = ProdW + 2;
   localparam int CntW   = $clog2(GaussDraws);
   localparam int PcW    = 5;

   localparam logic [LcgW-1:0] LcgMul   = LcgW'(1103515245);
   localparam logic [LcgW-1:0] LcgAdd   = LcgW'(12345);
   localparam logic [LcgW-1:0] LcgReset = LcgW'(1);

   localparam logic [OpW-1:0] OP_BIPOLAR  = 3'd0;
   localparam logic [OpW-1:0] OP_UNIPOLAR = 3'd1;
   localparam logic [OpW-1:0] OP_MIN      = 3'd2;
   localparam logic [OpW-1:0] OP_MAX      = 3'd3;
   localparam logic [OpW-1:0] OP_AVG      = 3'd4;
   localparam logic [OpW-1:0] OP_GAUSS    = 3'd5;

   localparam logic [PcW-1:0] PC_BIP   = 5'd0;
   localparam logic [PcW-1:0] PC_UNI   = 5'd2;
   localparam logic [PcW-1:0] PC_MIN   = 5'd4;
   localparam logic [PcW-1:0] PC_MAX   = 5'd7;
   localparam logic [PcW-1:0] PC_AVG   = 5'd10;
   localparam logic [PcW-1:0] PC_GAUSS = 5'd13;
   localparam logic [PcW-1:0] PC_GLOOP = 5'd14;
   localparam logic [PcW-1:0] PC_GADD  = 5'd15;
   localparam logic [PcW-1:0] PC_GMUL  = 5'd16;
   localparam logic [PcW-1:0] PC_GOUT  = 5'd17;
   localparam logic [PcW-1:0] PC_ZERO  = 5'd18;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_CLEAR,
      ACC_ADD,
      ACC_HOLD
   } acc_op_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_BIPOLAR,
      RES_UNIPOLAR,
      RES_MIN,
      RES_MAX,
      RES_AVG,
      RES_GAUSS
   } res_op_type;

   typedef struct packed {
      logic             draw;
      acc_op_type       acc_op;
      logic             cnt_load;
      logic             loop;
      logic [PcW-1:0]   target;
      logic             mul;
      res_op_type       res_op;
      logic             done;
   } ucode_type;

   function automatic logic [PcW-1:0] entry_pc(input logic [OpW-1:0] op);
      logic [PcW-1:0] pc;
      case (op)
         OP_BIPOLAR:  pc = PC_BIP;
         OP_UNIPOLAR: pc = PC_UNI;
         OP_MIN:      pc = PC_MIN;
         OP_MAX:      pc = PC_MAX;
         OP_AVG:      pc = PC_AVG;
         OP_GAUSS:    pc = PC_GAUSS;
         default:     pc = PC_ZERO;
      endcase
      return pc;
   endfunction

   function automatic ucode_type ucode(input logic [PcW-1:0] pc);
      ucode_type w;
      w = '{draw: 1'b0, acc_op: ACC_NONE, cnt_load: 1'b0, loop: 1'b0,
            target: '0, mul: 1'b0, res_op: RES_ZERO, done: 1'b0};
      case (pc)
         PC_BIP: w.draw = 1'b1;
         PC_BIP + 5'd1: begin
            w.res_op = RES_BIPOLAR;
            w.done   = 1'b1;
         end
         PC_UNI: w.draw = 1'b1;
         PC_UNI + 5'd1: begin
            w.res_op = RES_UNIPOLAR;
            w.done   = 1'b1;
         end
         PC_MIN: w.draw = 1'b1;
         PC_MIN + 5'd1: begin
            w.draw   = 1'b1;
            w.acc_op = ACC_HOLD;
         end
         PC_MIN + 5'd2: begin
            w.res_op = RES_MIN;
            w.done   = 1'b1;
         end
         PC_MAX: w.draw = 1'b1;
         PC_MAX + 5'd1: begin
            w.draw   = 1'b1;
            w.acc_op = ACC_HOLD;
         end
         PC_MAX + 5'd2: begin
            w.res_op = RES_MAX;
            w.done   = 1'b1;
         end
         PC_AVG: w.draw = 1'b1;
         PC_AVG + 5'd1: begin
            w.draw   = 1'b1;
            w.acc_op = ACC_HOLD;
         end
         PC_AVG + 5'd2: begin
            w.res_op = RES_AVG;
            w.done   = 1'b1;
         end
         PC_GAUSS: begin
            w.draw     = 1'b1;
            w.acc_op   = ACC_CLEAR;
            w.cnt_load = 1'b1;
         end
         PC_GLOOP: begin
            w.draw   = 1'b1;
            w.acc_op = ACC_ADD;
            w.loop   = 1'b1;
            w.target = PC_GLOOP;
         end
         PC_GADD: w.acc_op = ACC_ADD;
         PC_GMUL: w.mul = 1'b1;
         PC_GOUT: begin
            w.res_op = RES_GAUSS;
            w.done   = 1'b1;
         end
         PC_ZERO: begin
            w.res_op = RES_ZERO;
            w.done   = 1'b1;
         end
         default: begin
            w.res_op = RES_ZERO;
            w.done   = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

[sv/lrdg_req_if.sv]
// ---------------------------------------------------------------------------
// lrdg_req_if
// Request channel: one beat per random draw request.
// ---------------------------------------------------------------------------
interface lrdg_req_if
   import lrdg_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [OpW-1:0]         operation;
   logic signed [SigW-1:0] sigma;
   logic signed [SigW-1:0] mu;

   modport source (output valid, output operation, output sigma, output mu, input ready);
   modport sink   (input valid, input operation, input sigma, input mu, output ready);
endinterface

[sv/lrdg_rsp_if.sv]
// ---------------------------------------------------------------------------
// lrdg_rsp_if
// Response channel: one Q15.16 value beat per request.
// ---------------------------------------------------------------------------
interface lrdg_rsp_if
   import lrdg_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic signed [ValW-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

[sv/lrdg_lcg.sv]
// ---------------------------------------------------------------------------
// lrdg_lcg
// Congruential state register, one draw per advance, reloaded by seed writes.
// ---------------------------------------------------------------------------
module lrdg_lcg
   import lrdg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             seed_we,
   input  logic [SeedW-1:0] seed,
   input  logic             advance,
   output logic [UW-1:0]    u
);

   logic [LcgW-1:0] state_ff;
   logic [LcgW-1:0] state_in;

   always_comb begin
      state_in = state_ff;
      if (seed_we) begin
         state_in = seed[LcgW-1:0];
      end else if (advance) begin
         state_in = state_ff * LcgMul + LcgAdd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LcgReset;
      end else begin
         state_ff <= state_in;
      end
   end

   assign u = state_ff[LcgW-1 -: UW];

endmodule

[sv/lrdg_datapath.sv]
// ---------------------------------------------------------------------------
// lrdg_datapath
// Operand, accumulator and product registers plus result formatting.
// ---------------------------------------------------------------------------
module lrdg_datapath
   import lrdg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ucode_type              ctrl,
   input  logic                   load,
   input  logic signed [SigW-1:0] sigma,
   input  logic signed [SigW-1:0] mu,
   input  logic [UW-1:0]          u,
   output logic signed [ValW-1:0] value
);
   `include "assert_macros.svh"

   localparam logic signed [SatW-1:0] SatMax = SatW'(2147483647);
   localparam logic signed [SatW-1:0] SatMin = -SatMax - SatW'(1);

   logic [UW-1:0]          a_ff;
   logic [SumW-1:0]        acc_ff;
   logic [SumW-1:0]        acc_in;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [SigW-1:0] sigma_ff;
   logic signed [SigW-1:0] mu_ff;

   logic signed [DW-1:0]   cent;
   logic signed [ProdW-1:0] prod_in;
   logic signed [RndW-1:0] rnd;
   logic signed [SatW-1:0] gsum;
   logic signed [ValW-1:0] gval;
   logic [UW-1:0]          umin;
   logic [UW-1:0]          umax;

   always_comb begin
      case (ctrl.acc_op)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = acc_ff + SumW'(u);
         default:   acc_in = acc_ff;
      endcase
   end

   assign cent    = $signed({1'b0, acc_ff, 1'b0}) - DW'(GaussDraws * 32768);
   assign prod_in = sigma_ff * cent;

   always_ff @(posedge clock) begin
      if (load) begin
         sigma_ff <= sigma;
         mu_ff    <= mu;
      end
      if (ctrl.acc_op == ACC_HOLD) begin
         a_ff <= u;
      end
      acc_ff <= acc_in;
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
   end

   // round half up to Q16, add center, clamp
   assign rnd  = RndW'(prod_ff) + RndW'(32768);
   assign gsum = SatW'(rnd >>> FracW) + SatW'(mu_ff);

   always_comb begin
      if (gsum > SatMax) begin
         gval = ValW'(SatMax);
      end else if (gsum < SatMin) begin
         gval = ValW'(SatMin);
      end else begin
         gval = ValW'(gsum);
      end
   end

   assign umin = (u < a_ff) ? u : a_ff;
   assign umax = (u > a_ff) ? u : a_ff;

   always_comb begin
      case (ctrl.res_op)
         RES_BIPOLAR:  value = $signed({{(ValW-UW-2){1'b0}}, u, 2'b00}) - ValW'(65536);
         RES_UNIPOLAR: value = $signed({{(ValW-UW-1){1'b0}}, u, 1'b0});
         RES_MIN:      value = $signed({{(ValW-UW-1){1'b0}}, umin, 1'b0});
         RES_MAX:      value = $signed({{(ValW-UW-1){1'b0}}, umax, 1'b0});
         RES_AVG:      value = $signed(ValW'(a_ff) + ValW'(u));
         RES_GAUSS:    value = gval;
         default:      value = '0;
      endcase
   end

   `LRDG_ASSERT_STD(a_zero_spread, (ctrl.mul && sigma_ff == '0) |=> prod_ff == '0,
      "zero sigma gave nonzero product")

endmodule

[sv/lrdg_sequencer.sv]
// ---------------------------------------------------------------------------
// lrdg_sequencer
// Step counter, loop counter and microcode table lookup.
// ---------------------------------------------------------------------------
module lrdg_sequencer
   import lrdg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [OpW-1:0] op,
   input  logic           out_free,
   output logic           ready,
   output ucode_type      ctrl
);
   `include "assert_macros.svh"

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   seq_state_type   state_ff;
   seq_state_type   state_in;
   logic [PcW-1:0]  pc_ff;
   logic [PcW-1:0]  pc_in;
   logic [CntW-1:0] cnt_ff;
   logic [CntW-1:0] cnt_in;
   ucode_type       w;

   assign w = ucode(pc_ff);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               pc_in    = entry_pc(op);
            end
         end
         ST_RUN: begin
            if (w.done) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (w.loop && cnt_ff != '0) begin
               pc_in  = w.target;
               cnt_in = cnt_ff - CntW'(1);
            end else begin
               pc_in = pc_ff + PcW'(1);
            end
            if (w.cnt_load) begin
               cnt_in = CntW'(GaussDraws - 2);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign ready = (state_ff == ST_IDLE);
   assign ctrl  = (state_ff == ST_RUN) ? w : ucode_type'('0);

   `LRDG_ASSERT_STD(a_loop_branch,
      (state_ff == ST_RUN && w.loop && cnt_ff != '0) |=> pc_ff == $past(w.target),
      "loop branch not taken")
   `LRDG_ASSERT_STD(a_done_hold,
      (state_ff == ST_RUN && w.done && !out_free) |=> (state_ff == ST_RUN && $stable(pc_ff)),
      "final step left while output busy")

endmodule

[sv/lcg_random_distribution_generator.sv]
// Random value generator on the classic rand() congruential step. Each request
// beat selects bipolar/unipolar uniform, min, max or average of two draws, or a
// Gaussian sigma*(sum of 12 draws - 6)+mu, and returns one signed Q15.16 beat.
// One draw per cycle from the single state multiplier sets the rate. After
// accept, single-draw modes run a draw and a final step, two-draw modes two
// draws and a final step, the Gaussian GaussDraws draws, a multiply and a
// final step, unused codes only a final step (value 0, no draw). The
// sequencer goes idle before the next accept. A pending result does not block
// the next request. Writing csr_wdata reloads the state with its low 31 bits.
// ---------------------------------------------------------------------------
// lcg_random_distribution_generator
// Top level: request/response channels, seed register port, output register.
// ---------------------------------------------------------------------------
module lcg_random_distribution_generator
   import lrdg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [SeedW-1:0] csr_wdata,
   lrdg_req_if.sink         req,
   lrdg_rsp_if.source       rsp
);
   `include "assert_macros.svh"

   ucode_type              ctrl;
   logic                   start;
   logic                   seq_ready;
   logic                   out_free;
   logic                   load_out;
   logic [UW-1:0]          u;
   logic signed [ValW-1:0] dp_value;
   logic                   rsp_valid_ff;
   logic signed [ValW-1:0] rsp_value_ff;

   assign start    = req.valid && seq_ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign load_out = ctrl.done && out_free;

   lrdg_lcg u_lcg (
      .clock   (clock),
      .reset   (reset),
      .seed_we (csr_we),
      .seed    (csr_wdata),
      .advance (ctrl.draw),
      .u       (u)
   );

   lrdg_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req.operation),
      .out_free (out_free),
      .ready    (seq_ready),
      .ctrl     (ctrl)
   );

   lrdg_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .load  (start),
      .sigma (req.sigma),
      .mu    (req.mu),
      .u     (u),
      .value (dp_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         rsp_value_ff <= dp_value;
      end
   end

   assign req.ready = seq_ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.value = rsp_value_ff;

   `LRDG_ASSERT_STD(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(ctrl.done),
      "response beat without a final step")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Checks the lcg random generator against a cycle-free predictor of the
// congruential state. Every accepted request beat yields one expected value;
// every accepted response beat is checked in order. Seeds, idles and stalls
// on both channels are varied across several phases.
// ---------------------------------------------------------------------------
module tb;
   import lrdg_pkg::*;

   localparam logic [OpW-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;
   localparam int StallLimit  = 2000;
   localparam int SettleCycles = 24;

   class rand_value_scoreboard;
      logic [LcgW-1:0]        lcg;
      logic signed [ValW-1:0] expected_values[$];
      int                     errors;

      function new();
         lcg    = LcgReset;
         errors = 0;
      endfunction

      function void load_seed(logic [SeedW-1:0] seed);
         lcg = seed[LcgW-1:0];
      endfunction

      function longint draw_uniform();
         longint unsigned t;
         t   = 64'(lcg) * 64'(LcgMul) + 64'(LcgAdd);
         lcg = t[LcgW-1:0];
         return longint'(lcg[30:16]);
      endfunction

      function logic signed [ValW-1:0] predict_value(logic [OpW-1:0] op,
                                                     logic signed [SigW-1:0] sg,
                                                     logic signed [SigW-1:0] mu);
         longint a, b, sum, d, p, r;
         r = 0;
         case (op)
            OP_BIPOLAR:  r = 4 * draw_uniform() - 65536;
            OP_UNIPOLAR: r = 2 * draw_uniform();
            OP_MIN, OP_MAX, OP_AVG: begin
               a = draw_uniform();
               b = draw_uniform();
               if (op == OP_MIN)      r = 2 * ((b < a) ? b : a);
               else if (op == OP_MAX) r = 2 * ((b > a) ? b : a);
               else                   r = a + b;
            end
            OP_GAUSS: begin
               sum = 0;
               for (int i = 0; i < GaussDraws; i++) sum += draw_uniform();
               d = 2 * sum - longint'(GaussDraws) * 32768;
               p = longint'(sg) * d;
               r = ((p + 32768) >>> 16) + longint'(mu);
               if (r > 64'sd2147483647)  r = 64'sd2147483647;
               if (r < -64'sd2147483648) r = -64'sd2147483648;
            end
            OP_SPARE_LO, OP_SPARE_HI: r = 0;
            default: r = 0;
         endcase
         return r[ValW-1:0];
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function void note_request(logic [OpW-1:0] op, logic signed [SigW-1:0] sg,
                                 logic signed [SigW-1:0] mu);
         expected_values.push_back(predict_value(op, sg, mu));
      endfunction

      task check_result(logic signed [ValW-1:0] value);
         logic signed [ValW-1:0] want;
         if (expected_values.size() == 0) begin
            report($sformatf("unexpected value beat %0d", value));
         end else begin
            want = expected_values.pop_front();
            if (value !== want)
               report($sformatf("value got %0d (0x%08h) want %0d (0x%08h)",
                                value, value, want, want));
         end
      endtask

      task check_drained();
         if (expected_values.size() != 0)
            report($sformatf("%0d expected values never arrived",
                             expected_values.size()));
      endtask

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [SeedW-1:0] csr_wdata = '0;
   int               src_idle = 0;
   int               snk_idle = 0;
   int               stall_cycles = 0;

   rand_value_scoreboard sb = new();

   lrdg_req_if req_ch ();
   lrdg_rsp_if rsp_ch ();

   lcg_random_distribution_generator dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   always #1 clock = ~clock;

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.operation = '0;
      req_ch.sigma     = '0;
      req_ch.mu        = '0;
      rsp_ch.ready     = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.load_seed(csr_wdata);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.operation, req_ch.sigma, req_ch.mu);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.value);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("watchdog: no beat for %0d cycles", StallLimit);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at a falling edge
   task automatic send_request(logic [OpW-1:0] op, logic signed [SigW-1:0] sg,
                               logic signed [SigW-1:0] mu);
      while ($urandom_range(99) < src_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.sigma     <= sg;
      req_ch.mu        <= mu;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_seed(logic [SeedW-1:0] seed);
      csr_we    <= 1'b1;
      csr_wdata <= seed;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [SigW-1:0] pick_q7_16();
      case ($urandom_range(9))
         0:       return 24'sh7FFFFF;
         1:       return -24'sh800000;
         2:       return 24'sh010000;
         default: return SigW'($urandom);
      endcase
   endfunction

   task automatic run_phase(int n, int s_idle, int r_idle);
      logic [OpW-1:0] op;
      src_idle = s_idle;
      snk_idle = r_idle;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) wait_drain();
         op = ($urandom_range(9) == 0) ? OpW'($urandom_range(7))
                                       : OpW'($urandom_range(OP_GAUSS));
         send_request(op, pick_q7_16(), pick_q7_16());
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset seed, every operation, Q7.16 extremes
      src_idle = 10;
      snk_idle = 30;
      send_request(OP_BIPOLAR, '0, '0);
      send_request(OP_UNIPOLAR, '0, '0);
      send_request(OP_MIN, '0, '0);
      send_request(OP_MAX, '0, '0);
      send_request(OP_AVG, '0, '0);
      send_request(OP_GAUSS, 24'sh7FFFFF, 24'sh7FFFFF);
      send_request(OP_GAUSS, -24'sh800000, -24'sh800000);
      send_request(OP_GAUSS, 24'sh7FFFFF, -24'sh800000);
      send_request(OP_GAUSS, -24'sh800000, 24'sh7FFFFF);
      send_request(OP_GAUSS, '0, '0);
      send_request(OP_GAUSS, 24'sh010000, -24'sh000001);
      send_request(OP_SPARE_LO, 24'sh7FFFFF, -24'sh800000);
      send_request(OP_SPARE_HI, -24'sh800000, 24'sh7FFFFF);
      send_request(OP_BIPOLAR, '0, '0);
      wait_drain();

      write_seed(32'h0000_0000);
      send_request(OP_BIPOLAR, '0, '0);
      send_request(OP_GAUSS, 24'sh7FFFFF, '0);
      send_request(OP_MIN, '0, '0);
      wait_drain();

      write_seed(32'hFFFF_FFFF);
      send_request(OP_MAX, '0, '0);
      send_request(OP_AVG, '0, '0);
      send_request(OP_GAUSS, -24'sh800000, '0);
      wait_drain();

      write_seed(32'h8000_0000);
      send_request(OP_UNIPOLAR, '0, '0);
      send_request(OP_SPARE_HI, '0, '0);
      send_request(OP_UNIPOLAR, '0, '0);
      wait_drain();

      write_seed($urandom);
      run_phase(200, 23, 69);
      wait_drain();
      write_seed($urandom);
      run_phase(200, 69, 23);
      wait_drain();
      write_seed($urandom);
      run_phase(200, 0, 0);

      wait_drain();
      sb.check_drained();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/lrdg_pkg.sv
sv/lrdg_req_if.sv
sv/lrdg_rsp_if.sv
sv/lrdg_lcg.sv
sv/lrdg_datapath.sv
sv/lrdg_sequencer.sv
sv/lcg_random_distribution_generator.sv
tb/sv/tb.sv
